// ===== rtl/core/btpc_pkg.sv =====
// Shared types and constants for the barometer compensation pipeline.
// No dependencies.
`timescale 1ns / 1ps
package btpc_pkg;

   localparam int RawW = 20;
   localparam int CentiW = 16;
   localparam int FineW = 32;
   localparam int PressW = 20;
   localparam int Word32 = 32;
   localparam int DivStages = 32;

   localparam logic [1:0] CSR_TEMP = 2'd0;
   localparam logic [1:0] CSR_PLOW = 2'd1;
   localparam logic [1:0] CSR_PMID = 2'd2;
   localparam logic [1:0] CSR_PLAST = 2'd3;

   localparam logic signed [31:0] PressOffset = 32'sd64000;
   localparam logic signed [31:0] CentiRound = 32'sd128;
   localparam logic [31:0] PressBase = 32'd1048576;
   localparam logic [31:0] PressScale = 32'd3125;
   localparam logic [31:0] SplitPoint = 32'h8000_0000;
   localparam logic signed [31:0] Half = 32'sd32768;
   localparam logic signed [31:0] PressMax = 32'sd1048575;

   typedef struct packed {
      logic [15:0]        t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic [15:0]        p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
   } coeff_type;

   // Word that travels from the front datapath into the divider.
   typedef struct packed {
      logic signed [CentiW-1:0] tc;
      logic signed [FineW-1:0]  tf;
      logic [31:0]              dividend;
      logic [31:0]              divisor;
      logic                     split;
      logic                     fault;
   } div_req_type;

   typedef struct packed {
      logic signed [CentiW-1:0] tc;
      logic signed [FineW-1:0]  tf;
      logic [31:0]              quot;
      logic                     split;
      logic                     fault;
   } div_rsp_type;

endpackage

// ===== rtl/core/btpc_front.sv =====
// Front datapath: fine temperature, centi-degree value and pressure dividend/divisor.
// Depends on btpc_pkg.
`timescale 1ns / 1ps
module btpc_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  logic [19:0]            raw_t,
   input  logic [19:0]            raw_p,
   input  btpc_pkg::coeff_type    cf,
   output logic                   out_valid,
   output btpc_pkg::div_req_type  out_word
);
   import btpc_pkg::*;

   localparam int Depth = 6;

   logic [Depth-1:0] vld_ff, vld_in;

   // stage 1
   logic signed [31:0] s1_v1m_ff, s1_v1m_in, s1_dd_ff, s1_dd_in;
   logic [19:0] s1_p_ff, s1_p_in;
   // stage 2
   logic signed [31:0] s2_v1_ff, s2_v1_in, s2_v2m_ff, s2_v2m_in;
   logic [19:0] s2_p_ff, s2_p_in;
   // stage 3
   logic signed [31:0] s3_tf_ff, s3_tf_in, s3_a_ff, s3_a_in, s3_sq_ff, s3_sq_in;
   logic [19:0] s3_p_ff, s3_p_in;
   // stage 4
   logic signed [31:0] s4_b6_ff, s4_b6_in, s4_a5_ff, s4_a5_in, s4_x3_ff, s4_x3_in;
   logic signed [31:0] s4_x2_ff, s4_x2_in, s4_tf_ff, s4_tf_in;
   logic [19:0] s4_p_ff, s4_p_in;
   // stage 5
   logic signed [31:0] s5_b_ff, s5_b_in, s5_a_ff, s5_a_in, s5_tf_ff, s5_tf_in;
   logic [19:0] s5_p_ff, s5_p_in;
   // stage 6
   div_req_type s6_ff, s6_in;

   logic signed [31:0] tb, td, t4, tcw;
   logic signed [31:0] b_sum, a_sum, pdiff, pmul;
   logic signed [31:0] prod;
   logic signed [31:0] tc32;
   logic [31:0] pdv;

   always_comb begin
      vld_in = {vld_ff[Depth-2:0], in_valid};
      tb = 32'(signed'({12'd0, raw_t} >> 3)) - 32'(signed'({16'd0, cf.t1} << 1));
      s1_v1m_in = 32'(tb * 32'(cf.t2));
      td = 32'(signed'({12'd0, raw_t} >> 4)) - 32'(signed'({16'd0, cf.t1}));
      s1_dd_in = 32'(td * td);
      s1_p_in = raw_p;

      s2_v1_in = s1_v1m_ff >>> 11;
      s2_v2m_in = 32'((s1_dd_ff >>> 12) * 32'(cf.t3));
      s2_p_in = s1_p_ff;

      s3_tf_in = s2_v1_ff + (s2_v2m_ff >>> 14);
      t4 = (s3_tf_in >>> 1) - PressOffset;
      s3_a_in = t4;
      s3_sq_in = 32'((t4 >>> 2) * (t4 >>> 2));
      s3_p_in = s2_p_ff;

      s4_b6_in = 32'((s3_sq_ff >>> 11) * 32'(cf.p6));
      s4_a5_in = 32'(s3_a_ff * 32'(cf.p5));
      s4_x3_in = 32'(32'(cf.p3) * (s3_sq_ff >>> 13));
      s4_x2_in = 32'(32'(cf.p2) * s3_a_ff);
      s4_tf_in = s3_tf_ff;
      s4_p_in = s3_p_ff;

      b_sum = s4_b6_ff + (s4_a5_ff <<< 1);
      s5_b_in = (b_sum >>> 2) + (32'(cf.p4) <<< 16);
      a_sum = ((s4_x3_ff >>> 3) + (s4_x2_ff >>> 1)) >>> 18;
      s5_a_in = Half + a_sum;
      s5_tf_in = s4_tf_ff;
      s5_p_in = s4_p_ff;

      // Wrap the divisor product at 32 bits before the arithmetic shift.
      prod = 32'(s5_a_ff * signed'({16'd0, cf.p1}));
      pmul = prod >>> 15;
      tcw = 32'(s5_tf_ff * 32'sd5) + CentiRound;
      tc32 = tcw >>> 8;
      pdiff = signed'(PressBase - {12'd0, s5_p_ff}) - (s5_b_ff >>> 12);
      pdv = 32'(32'(pdiff) * PressScale);
      s6_in.tf = s5_tf_ff;
      if (tc32 > 32'sd32767) s6_in.tc = 16'sh7fff;
      else if (tc32 < -32'sd32768) s6_in.tc = -16'sh8000;
      else s6_in.tc = tc32[15:0];
      s6_in.divisor = pmul;
      s6_in.fault = (pmul == 32'd0);
      s6_in.split = (pdv >= SplitPoint);
      s6_in.dividend = s6_in.split ? pdv : {pdv[30:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
      if (adv) begin
         s1_v1m_ff <= s1_v1m_in; s1_dd_ff <= s1_dd_in; s1_p_ff <= s1_p_in;
         s2_v1_ff <= s2_v1_in; s2_v2m_ff <= s2_v2m_in; s2_p_ff <= s2_p_in;
         s3_tf_ff <= s3_tf_in; s3_a_ff <= s3_a_in; s3_sq_ff <= s3_sq_in;
         s3_p_ff <= s3_p_in;
         s4_b6_ff <= s4_b6_in; s4_a5_ff <= s4_a5_in; s4_x3_ff <= s4_x3_in;
         s4_x2_ff <= s4_x2_in; s4_tf_ff <= s4_tf_in; s4_p_ff <= s4_p_in;
         s5_b_ff <= s5_b_in; s5_a_ff <= s5_a_in; s5_tf_ff <= s5_tf_in;
         s5_p_ff <= s5_p_in;
         s6_ff <= s6_in;
      end
   end

   assign out_valid = vld_ff[Depth-1];
   assign out_word = s6_ff;
endmodule

// ===== rtl/core/btpc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, 32-bit unsigned.
// Depends on btpc_pkg.
`timescale 1ns / 1ps
module btpc_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  btpc_pkg::div_req_type  in_word,
   output logic                   out_valid,
   output btpc_pkg::div_rsp_type  out_word
);
   import btpc_pkg::*;

   logic [DivStages-1:0] vld_ff;
   logic [31:0] rem_ff [DivStages];
   logic [31:0] num_ff [DivStages];
   logic [31:0] den_ff [DivStages];
   div_rsp_type side_ff [DivStages];

   logic [32:0] trial [DivStages];
   logic [31:0] rem_in [DivStages];
   logic [31:0] num_in [DivStages];

   always_comb begin
      for (int k = 0; k < DivStages; k++) begin
         if (k == 0) begin
            trial[k] = {32'd0, in_word.dividend[31]};
            num_in[k] = {in_word.dividend[30:0], 1'b0};
         end else begin
            trial[k] = {rem_ff[k-1], num_ff[k-1][31]};
            num_in[k] = {num_ff[k-1][30:0], 1'b0};
         end
         if (k == 0) begin
            if (trial[k] >= {1'b0, in_word.divisor}) begin
               rem_in[k] = 32'(trial[k] - {1'b0, in_word.divisor});
               num_in[k][0] = 1'b1;
            end else begin
               rem_in[k] = trial[k][31:0];
            end
         end else begin
            if (trial[k] >= {1'b0, den_ff[k-1]}) begin
               rem_in[k] = 32'(trial[k] - {1'b0, den_ff[k-1]});
               num_in[k][0] = 1'b1;
            end else begin
               rem_in[k] = trial[k][31:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DivStages-2:0], in_valid};
      end
      if (adv) begin
         rem_ff[0] <= rem_in[0];
         num_ff[0] <= num_in[0];
         den_ff[0] <= in_word.divisor;
         side_ff[0].tc <= in_word.tc;
         side_ff[0].tf <= in_word.tf;
         side_ff[0].split <= in_word.split;
         side_ff[0].fault <= in_word.fault;
         side_ff[0].quot <= '0;
         for (int k = 1; k < DivStages; k++) begin
            rem_ff[k] <= rem_in[k];
            num_ff[k] <= num_in[k];
            den_ff[k] <= den_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   always_comb begin
      out_valid = vld_ff[DivStages-1];
      out_word = side_ff[DivStages-1];
      out_word.quot = num_ff[DivStages-1];
   end
endmodule

// ===== rtl/core/btpc_back.sv =====
// Back datapath: split fixup, second-order pressure correction and saturation.
// Depends on btpc_pkg.
`timescale 1ns / 1ps
module btpc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  btpc_pkg::div_rsp_type  in_word,
   input  btpc_pkg::coeff_type    cf,
   output logic                   out_valid,
   output logic signed [15:0]     tc,
   output logic signed [31:0]     tf,
   output logic [19:0]            pa,
   output logic                   fault
);
   import btpc_pkg::*;

   logic [2:0] vld_ff;
   // stage A: final quotient, square
   logic [31:0] a_p_ff, a_p_in, a_pp_ff, a_pp_in;
   div_rsp_type a_s_ff, b_s_ff, c_s_ff;
   // stage B: coefficient products
   logic signed [31:0] b_m9_ff, b_m9_in, b_m8_ff, b_m8_in;
   logic [31:0] b_p_ff;
   // stage C: sum and clamp
   logic [19:0] c_pa_ff, c_pa_in;

   logic [31:0] q;
   logic signed [31:0] pr, corr;

   always_comb begin
      q = in_word.quot;
      a_p_in = in_word.split ? {q[30:0], 1'b0} : q;
      a_pp_in = 32'({3'd0, a_p_in[31:3]} * {3'd0, a_p_in[31:3]});
      b_m9_in = 32'(32'(cf.p9) * signed'({13'd0, a_pp_ff[31:13]}));
      b_m8_in = 32'(signed'({2'd0, a_p_ff[31:2]}) * 32'(cf.p8));
      corr = ((b_m9_ff >>> 12) + (b_m8_ff >>> 13) + 32'(cf.p7)) >>> 4;
      pr = signed'(b_p_ff) + corr;
      if (b_s_ff.fault) c_pa_in = '0;
      else if (pr < 0) c_pa_in = '0;
      else if (pr > PressMax) c_pa_in = 20'hfffff;
      else c_pa_in = pr[19:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
      if (adv) begin
         a_p_ff <= a_p_in; a_pp_ff <= a_pp_in; a_s_ff <= in_word;
         b_m9_ff <= b_m9_in; b_m8_ff <= b_m8_in; b_p_ff <= a_p_ff; b_s_ff <= a_s_ff;
         c_pa_ff <= b_s_ff.fault ? '0 : c_pa_in; c_s_ff <= b_s_ff;
      end
   end

   assign out_valid = vld_ff[2];
   assign tc = c_s_ff.tc;
   assign tf = c_s_ff.tf;
   assign pa = c_pa_ff;
   assign fault = c_s_ff.fault;
endmodule

// ===== rtl/core/baro_temp_pressure_compensation.sv =====
// Top level of the barometer temperature/pressure compensation pipeline.
// Depends on btpc_pkg, btpc_front, btpc_div, btpc_back.
//
//   channel  dir  handshake        payload
//   req_     in   valid / stall    raw_temperature, raw_pressure
//   rsp_     out  valid / stall    temperature_centi, fine_temperature, pressure_pa,
//                                  divide_fault
//   csr_     in   valid / ready    index (2 bits), data (64 bits)
//
// One word enters per cycle while req_stall is low; the stages are 6 front, 32 divider, 3 back.
// The 32-stage divider, one quotient bit per stage, sets the latency.
// Synchronous active-high reset clears the valid bits and the coefficients.
// The whole pipe holds while the last stage holds a word and rsp_stall is high;
// req_stall follows that hold, so nothing is dropped or repeated.
`timescale 1ns / 1ps
module baro_temp_pressure_compensation (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [19:0]        req_raw_temperature,
   input  logic [19:0]        req_raw_pressure,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_temperature_centi,
   output logic signed [31:0] rsp_fine_temperature,
   output logic [19:0]        rsp_pressure_pa,
   output logic               rsp_divide_fault,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [63:0]        csr_data
);
   import btpc_pkg::*;

   logic [47:0] temp_ff;
   logic [63:0] plow_ff, pmid_ff;
   logic [15:0] plast_ff;
   coeff_type cf;
   logic adv;
   logic f_valid, d_valid;
   div_req_type f_word;
   div_rsp_type d_word;

   // Advance everything unless the output word is held.
   assign adv = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff <= '0; plow_ff <= '0; pmid_ff <= '0; plast_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TEMP:  temp_ff <= csr_data[47:0];
            CSR_PLOW:  plow_ff <= csr_data;
            CSR_PMID:  pmid_ff <= csr_data;
            CSR_PLAST: plast_ff <= csr_data[15:0];
            default:   ;
         endcase
      end
   end

   always_comb begin
      cf.t1 = temp_ff[15:0];  cf.t2 = temp_ff[31:16]; cf.t3 = temp_ff[47:32];
      cf.p1 = plow_ff[15:0];  cf.p2 = plow_ff[31:16]; cf.p3 = plow_ff[47:32];
      cf.p4 = plow_ff[63:48];
      cf.p5 = pmid_ff[15:0];  cf.p6 = pmid_ff[31:16]; cf.p7 = pmid_ff[47:32];
      cf.p8 = pmid_ff[63:48];
      cf.p9 = plast_ff;
   end

   btpc_front u_front (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(req_valid),
      .raw_t(req_raw_temperature), .raw_p(req_raw_pressure), .cf(cf),
      .out_valid(f_valid), .out_word(f_word)
   );

   btpc_div u_div (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(f_valid),
      .in_word(f_word), .out_valid(d_valid), .out_word(d_word)
   );

   btpc_back u_back (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(d_valid),
      .in_word(d_word), .cf(cf), .out_valid(rsp_valid),
      .tc(rsp_temperature_centi), .tf(rsp_fine_temperature),
      .pa(rsp_pressure_pa), .fault(rsp_divide_fault)
   );
endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for baro_temp_pressure_compensation.
// Depends on btpc_pkg and the compensation RTL; a scoreboard class predicts each result.
`timescale 1ns / 1ps
module tb_top;
   import btpc_pkg::*;

   // Holds the calibration copy, computes the expected result words and checks them.
   class comp_scoreboard;
      logic [47:0] temp_coeffs;
      logic [63:0] plow, pmid;
      logic [15:0] plast;
      logic [15:0] exp_tc[$];
      logic [31:0] exp_tf[$];
      logic [19:0] exp_pa[$];
      logic        exp_fault[$];
      int          errors;

      function new();
         temp_coeffs = '0;
         plow = '0;
         pmid = '0;
         plast = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [63:0] data);
         case (idx)
            CSR_TEMP:  temp_coeffs = data[47:0];
            CSR_PLOW:  plow = data;
            CSR_PMID:  pmid = data;
            CSR_PLAST: plast = data[15:0];
         endcase
      endfunction

      function int pending();
         return exp_tc.size();
      endfunction

      // Compensate one raw pair; all intermediates wrap at 32 bits.
      function void note_sample(logic [19:0] raw_t, logic [19:0] raw_p);
         logic signed [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
         logic signed [31:0] v1, v2, d, tf, tc, a, q, sq, b, pr;
         logic [31:0] p, dvs, pp;
         logic fault;
         t1 = {16'd0, temp_coeffs[15:0]};
         t2 = {{16{temp_coeffs[31]}}, temp_coeffs[31:16]};
         t3 = {{16{temp_coeffs[47]}}, temp_coeffs[47:32]};
         p1 = {16'd0, plow[15:0]};
         p2 = {{16{plow[31]}}, plow[31:16]};
         p3 = {{16{plow[47]}}, plow[47:32]};
         p4 = {{16{plow[63]}}, plow[63:48]};
         p5 = {{16{pmid[15]}}, pmid[15:0]};
         p6 = {{16{pmid[31]}}, pmid[31:16]};
         p7 = {{16{pmid[47]}}, pmid[47:32]};
         p8 = {{16{pmid[63]}}, pmid[63:48]};
         p9 = {{16{plast[15]}}, plast};
         v1 = ((($signed({12'd0, raw_t}) >>> 3) - t1 * 2) * t2) >>> 11;
         d = ($signed({12'd0, raw_t}) >>> 4) - t1;
         v2 = (((d * d) >>> 12) * t3) >>> 14;
         tf = v1 + v2;
         tc = (tf * 5 + 128) >>> 8;
         if (tc > 32767) tc = 32767;
         if (tc < -32768) tc = -32768;
         a = (tf >>> 1) - 64000;
         q = a >>> 2;
         sq = q * q;
         b = (sq >>> 11) * p6;
         b = b + (a * p5) * 2;
         b = (b >>> 2) + p4 * 65536;
         a = (((p3 * (sq >>> 13)) >>> 3) + ((p2 * a) >>> 1)) >>> 18;
         a = ((32768 + a) * p1) >>> 15;
         fault = (a == 0);
         pr = 0;
         if (!fault) begin
            p = (32'd1048576 - {12'd0, raw_p}) - $unsigned(b >>> 12);
            p = p * 32'd3125;
            dvs = a;
            if (p < 32'h8000_0000) p = (p << 1) / dvs;
            else p = (p / dvs) * 2;
            pp = (p >> 3) * (p >> 3);
            v1 = (p9 * $signed(pp >> 13)) >>> 12;
            v2 = ($signed(p >> 2) * p8) >>> 13;
            pr = $signed(p) + ((v1 + v2 + p7) >>> 4);
            if (pr < 0) pr = 0;
            if (pr > 1048575) pr = 1048575;
         end
         exp_tc.push_back(tc[15:0]);
         exp_tf.push_back(tf);
         exp_pa.push_back(pr[19:0]);
         exp_fault.push_back(fault);
      endfunction

      function void check_result(logic [15:0] tc, logic [31:0] tf, logic [19:0] pa,
                                 logic fault);
         logic [15:0] e_tc;
         logic [31:0] e_tf;
         logic [19:0] e_pa;
         logic        e_f;
         if (exp_tc.size() == 0) begin
            $error("result word with no expectation waiting");
            errors++;
            return;
         end
         e_tc = exp_tc.pop_front();
         e_tf = exp_tf.pop_front();
         e_pa = exp_pa.pop_front();
         e_f = exp_fault.pop_front();
         if (tc !== e_tc) begin
            $error("temperature_centi expected %0d actual %0d", $signed(e_tc), $signed(tc));
            errors++;
         end
         if (tf !== e_tf) begin
            $error("fine_temperature expected %0d actual %0d", $signed(e_tf), $signed(tf));
            errors++;
         end
         if (pa !== e_pa) begin
            $error("pressure_pa expected %0d actual %0d", e_pa, pa);
            errors++;
         end
         if (fault !== e_f) begin
            $error("divide_fault expected %0d actual %0d", e_f, fault);
            errors++;
         end
      endfunction
   endclass

   localparam int Latency = 41;
   localparam int WatchLimit = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [19:0] req_raw_temperature = '0;
   logic [19:0] req_raw_pressure = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic signed [15:0] rsp_temperature_centi;
   logic signed [31:0] rsp_fine_temperature;
   logic [19:0] rsp_pressure_pa;
   logic        rsp_divide_fault;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   comp_scoreboard sb = new();
   int  idle_pct = 22;  // idle chance in percent for both sides; zero for a quiet stretch
   int  quiet_cycles;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   baro_temp_pressure_compensation dut (.*);

   // Sample results at the rising edge; note accepted words; count quiet cycles.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_temperature_centi, rsp_fine_temperature,
                            rsp_pressure_pa, rsp_divide_fault);
         if (req_valid && !req_stall)
            sb.note_sample(req_raw_temperature, req_raw_pressure);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) || (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end else begin
         quiet_cycles <= 0;
      end
   end

   // Receiver stalls at random; change it on the falling edge only.
   always @(negedge clock) begin
      rsp_stall <= (idle_pct > 0) && ($urandom_range(99) < idle_pct);
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (quiet_cycles >= WatchLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Drive one register write and wait for the handshake.
   task automatic write_csr(logic [1:0] idx, logic [63:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Send one raw pair, with a random idle gap before it.
   task automatic send_sample(logic [19:0] raw_t, logic [19:0] raw_p);
      @(negedge clock);
      while ((idle_pct > 0) && ($urandom_range(99) < idle_pct)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_raw_temperature <= raw_t;
      req_raw_pressure <= raw_p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid and wait for every expected word, then let the pipe drain.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (Latency + 4) @(posedge clock);
   endtask

   // Load a full calibration set.
   task automatic load_coeffs(logic [47:0] tc, logic [63:0] lo, logic [63:0] mid,
                              logic [15:0] last);
      write_csr(CSR_TEMP, {16'hFFFF, tc});  // upper bits must be dropped
      write_csr(CSR_PLOW, lo);
      write_csr(CSR_PMID, mid);
      write_csr(CSR_PLAST, {48'h1234_5678_9ABC, last});
   endtask

   // Typical factory calibration set, also used for random-traffic sets 0 and 3.
   localparam logic [47:0] TypT = {16'hFC18, 16'h6810, 16'h6E2C};  // T3=-1000 T2 T1
   localparam logic [63:0] TypPL = {16'h2B8E, 16'h0BD0, 16'hD5D4, 16'h8E4A};
   localparam logic [63:0] TypPM = {16'hE814, 16'h3A98, 16'hFFF9, 16'h008C};
   localparam logic [15:0] TypP9 = 16'h1770;

   initial begin
      int k, set;
      quiet_cycles = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset coefficients give zero divisor and fault.
      send_sample(20'd0, 20'd0);
      send_sample(20'hFFFFF, 20'hFFFFF);
      drain();

      load_coeffs(TypT, TypPL, TypPM, TypP9);
      send_sample(20'd519888, 20'd415148);
      send_sample(20'd0, 20'd0);
      send_sample(20'hFFFFF, 20'hFFFFF);
      send_sample(20'hFFFFF, 20'd0);
      send_sample(20'd0, 20'hFFFFF);
      send_sample(20'h80000, 20'h80000);
      send_sample(20'h7FFFF, 20'h7FFFF);
      drain();

      // Extreme coefficients: saturation, wrap and the dividend split.
      load_coeffs({16'h7FFF, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
                  {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 16'h7FFF);
      send_sample(20'd0, 20'd0);
      send_sample(20'hFFFFF, 20'hFFFFF);
      send_sample(20'h12345, 20'hABCDE);
      drain();
      load_coeffs({16'h8000, 16'h8000, 16'h0000}, {16'h8000, 16'h8000, 16'h8000, 16'h0001},
                  {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 16'h8000);
      send_sample(20'd0, 20'd0);
      send_sample(20'hFFFFF, 20'hFFFFF);
      send_sample(20'h55555, 20'hAAAAA);
      drain();

      // Random traffic over several calibration sets; the sender pauses
      // for a full drain between sets.
      for (set = 0; set < 6; set++) begin
         if (set == 0 || set == 3)
            load_coeffs(TypT, TypPL, TypPM, TypP9);
         else
            load_coeffs(48'({$urandom, $urandom}), {$urandom, $urandom},
                        {$urandom, $urandom}, 16'($urandom));
         if (set == 2) idle_pct = 0;  // long stretch with no idling
         for (k = 0; k < 200; k++) begin
            if (set == 0 || set == 3 || $urandom_range(3) != 0)
               send_sample(20'($urandom_range(600000, 400000)),
                           20'($urandom_range(500000, 250000)));
            else
               send_sample(20'($urandom), 20'($urandom));
         end
         idle_pct = 22;
         drain();
      end

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
